/* rtl/core/target_decoy_qvalue_engine_core_defines.svh */
// assertion macros used by the checker file
`ifndef TARGET_DECOY_QVALUE_ENGINE_CORE_DEFINES_SVH
`define TARGET_DECOY_QVALUE_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TDQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define TDQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tdq_pkg.sv */
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types and constants of the target/decoy q-value engine.
// ----------------------------------------------------------------------------
`default_nettype none

package tdq_pkg;

    // defaults of the top-level parameters
    localparam int DEF_MAX_ITEMS  = 64;
    localparam int DEF_SCORE_BITS = 32;

    // field widths
    localparam int SCORE_W     = 32;
    localparam int EXT_SCORE_W = 48;
    localparam int INDEX_W     = 6;
    localparam int Q_W         = 16;
    localparam int PASS_W      = 7;
    localparam int THR_W       = 16;
    localparam int PI0_W       = 16;
    localparam int RATIO_W     = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 2;

    // register reset values
    localparam logic [THR_W-1:0]   THR_RESET   = 16'd655;
    localparam logic [PI0_W-1:0]   PI0_RESET   = 16'd58982;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 24'd65536;

    // register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FDR_THRESHOLD = 2'd0,
        CFG_NULL_FRACTION = 2'd1,
        CFG_DECOY_RATIO   = 2'd2
    } t_cfg_index;

    // input item
    typedef struct packed {
        logic signed [SCORE_W-1:0] score;
        logic                      is_decoy;
        logic                      last;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [INDEX_W-1:0] item_index;
        logic [Q_W-1:0]     q_value;
        logic [PASS_W-1:0]  targets_passing;
        logic               last_result;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/core/tdq_divider.sv */
// ----------------------------------------------------------------------------
// tdq_divider
// Restoring divider, one quotient bit per cycle. The dividend must be
// below divisor * 2^16, so the quotient fits in 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tdq_divider #(
    parameter int CNT_W = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [CNT_W+tdq_pkg::Q_W-1:0] i_dividend,
    input  wire logic [CNT_W-1:0]              i_divisor,
    output logic                               o_done,
    output logic [tdq_pkg::Q_W-1:0]            o_quotient
);

    localparam int QW     = tdq_pkg::Q_W;
    localparam int STEP_W = $clog2(QW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic [QW-1:0]     r_quo;

    logic [CNT_W:0]    w_trial;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    // trial subtract of one step
    always_comb begin
        w_trial = {r_rem, r_quo[QW-1]};
        w_ge    = w_trial >= {1'b0, r_div};
        w_diff  = w_trial - {1'b0, r_div};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend[CNT_W+QW-1:QW];
            r_quo <= i_dividend[QW-1:0];
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
            r_quo <= {r_quo[QW-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* rtl/core/target_decoy_qvalue_engine_core.sv */
// ----------------------------------------------------------------------------
// target_decoy_qvalue_engine_core
// Ranks scored target/decoy items and emits a monotone q value per rank.
// ----------------------------------------------------------------------------
// Items are taken one at a time; input ready is high only while the block
// is idle. Each item is placed into a descending ranked store by a walk from
// the bottom of the store, with a read and a write per stored entry that is
// compared; an item that arrives while the store is full is dropped. The item
// carrying last then starts the scan: per rank a read, a count, a multiply, a
// clamp and a write, with the bit-serial divider where a real division is
// needed, then a backward minimum pass over the ranks and a read, load and
// hold per result. Results appear in rank order, best first, and the block
// takes no new item until the final result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module target_decoy_qvalue_engine_core #(
    parameter int MAX_ITEMS  = tdq_pkg::DEF_MAX_ITEMS,
    parameter int SCORE_BITS = tdq_pkg::DEF_SCORE_BITS
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tdq_pkg::t_in_item                 i_in_data,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tdq_pkg::t_out_item                     o_out_data,
    input  wire logic                              i_cfg_we,
    input  wire logic [tdq_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [tdq_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW      = $clog2(MAX_ITEMS);
    localparam int CW      = $clog2(MAX_ITEMS + 1);
    localparam int IW      = tdq_pkg::INDEX_W;
    localparam int QW      = tdq_pkg::Q_W;
    localparam int PR_W    = tdq_pkg::PI0_W + tdq_pkg::RATIO_W;
    localparam int PROD_W  = PR_W + CW;
    localparam int D_W     = PROD_W - QW;

    typedef struct packed {
        logic signed [SCORE_BITS-1:0] score;
        logic                         decoy;
        logic [IW-1:0]                idx;
    } t_entry;

    typedef enum logic [14:0] {
        S_IDLE     = 15'b000000000000001,
        S_INS_RD   = 15'b000000000000010,
        S_INS_CMP  = 15'b000000000000100,
        S_SC_INIT  = 15'b000000000001000,
        S_SC_RD    = 15'b000000000010000,
        S_SC_CNT   = 15'b000000000100000,
        S_SC_MUL   = 15'b000000001000000,
        S_SC_Q     = 15'b000000010000000,
        S_SC_DIV   = 15'b000000100000000,
        S_SC_WR    = 15'b000001000000000,
        S_MIN_RD   = 15'b000010000000000,
        S_MIN_WR   = 15'b000100000000000,
        S_OUT_RD   = 15'b001000000000000,
        S_OUT_LD   = 15'b010000000000000,
        S_OUT_HOLD = 15'b100000000000000
    } t_state;

    // configuration registers
    logic [tdq_pkg::THR_W-1:0]   r_thr;
    logic [tdq_pkg::PI0_W-1:0]   r_pi0;
    logic [tdq_pkg::RATIO_W-1:0] r_ratio;

    // control and datapath registers
    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            r_k, n_k;
    logic signed [SCORE_BITS-1:0] r_key, n_key;
    logic                     r_decoy, n_decoy;
    logic                     r_last, n_last;
    logic [PR_W-1:0]          r_pr, n_pr;
    logic [PROD_W-1:0]        r_prod, n_prod;
    logic [CW-1:0]            r_targets, n_targets;
    logic [CW-1:0]            r_decoys, n_decoys;
    logic [CW-1:0]            r_passing, n_passing;
    logic [QW-1:0]            r_q, n_q;
    logic [QW-1:0]            r_min, n_min;
    logic                     r_out_valid, n_out_valid;
    tdq_pkg::t_out_item       r_out, n_out;

    // memories
    t_entry                   item_mem [MAX_ITEMS];
    logic [QW-1:0]            q_mem [MAX_ITEMS];
    t_entry                   r_item_rd;
    logic [QW-1:0]            r_q_rd;

    logic                     w_item_we, w_item_re;
    logic [AW-1:0]            w_item_waddr, w_item_raddr;
    t_entry                   w_item_wdata;
    logic                     w_q_we, w_q_re;
    logic [AW-1:0]            w_q_waddr, w_q_raddr;
    logic [QW-1:0]            w_q_wdata;

    // divider hookup
    logic                     w_div_start;
    logic                     w_div_done;
    logic [QW-1:0]            w_div_quo;

    logic                     w_in_xfer;
    logic [tdq_pkg::EXT_SCORE_W-1:0] w_score_ext;
    logic [CW-1:0]            w_km1;
    logic [CW-1:0]            w_cm1;
    logic [D_W-1:0]           w_dvd;
    logic [D_W-1:0]           w_lim;
    logic [QW-1:0]            w_pi0_q;
    t_entry                   w_new;

    tdq_divider #(
        .CNT_W (CW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd[CW+QW-1:0]),
        .i_divisor  (r_targets),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= tdq_pkg::THR_RESET;
            r_pi0   <= tdq_pkg::PI0_RESET;
            r_ratio <= tdq_pkg::RATIO_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tdq_pkg::CFG_FDR_THRESHOLD: r_thr   <= i_cfg_data[tdq_pkg::THR_W-1:0];
                tdq_pkg::CFG_NULL_FRACTION: r_pi0   <= i_cfg_data[tdq_pkg::PI0_W-1:0];
                tdq_pkg::CFG_DECOY_RATIO:   r_ratio <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // helper values
    always_comb begin
        w_in_xfer   = i_in_valid && o_in_ready;
        w_score_ext = {{(tdq_pkg::EXT_SCORE_W - tdq_pkg::SCORE_W){i_in_data.score[tdq_pkg::SCORE_W-1]}},
                       i_in_data.score};
        w_km1       = r_k - CW'(1);
        w_cm1       = r_count - CW'(1);
        w_dvd       = r_prod[PROD_W-1:QW];
        w_lim       = D_W'({r_targets, {QW{1'b0}}});
        w_pi0_q     = r_pi0;
        w_new.score = r_key;
        w_new.decoy = r_decoy;
        w_new.idx   = IW'(r_count);
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_k          = r_k;
        n_key        = r_key;
        n_decoy      = r_decoy;
        n_last       = r_last;
        n_pr         = r_pr;
        n_prod       = r_prod;
        n_targets    = r_targets;
        n_decoys     = r_decoys;
        n_passing    = r_passing;
        n_q          = r_q;
        n_min        = r_min;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        w_item_we    = 1'b0;
        w_item_waddr = AW'(r_k);
        w_item_wdata = w_new;
        w_item_re    = 1'b0;
        w_item_raddr = AW'(r_k);
        w_q_we       = 1'b0;
        w_q_waddr    = AW'(r_k);
        w_q_wdata    = r_q;
        w_q_re       = 1'b0;
        w_q_raddr    = AW'(r_k);
        w_div_start  = 1'b0;

        unique case (r_state)
            // take an item
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_key   = w_score_ext[SCORE_BITS-1:0];
                    n_decoy = i_in_data.is_decoy;
                    n_last  = i_in_data.last;
                    if (r_count < CW'(MAX_ITEMS)) begin
                        n_k     = r_count;
                        n_state = S_INS_RD;
                    end else if (i_in_data.last) begin
                        n_state = S_SC_INIT;
                    end
                end
            end
            // walk up from the bottom of the ranked store
            S_INS_RD: begin
                if (r_k == '0) begin
                    w_item_we    = 1'b1;
                    w_item_waddr = '0;
                    n_count      = r_count + CW'(1);
                    n_state      = r_last ? S_SC_INIT : S_IDLE;
                end else begin
                    w_item_re    = 1'b1;
                    w_item_raddr = AW'(w_km1);
                    n_state      = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                w_item_we    = 1'b1;
                w_item_waddr = AW'(r_k);
                if (r_item_rd.score > r_key) begin
                    n_count = r_count + CW'(1);
                    n_state = r_last ? S_SC_INIT : S_IDLE;
                end else begin
                    w_item_wdata = r_item_rd;
                    n_k          = w_km1;
                    n_state      = S_INS_RD;
                end
            end
            // scan setup
            S_SC_INIT: begin
                n_pr      = PR_W'(r_pi0) * PR_W'(r_ratio);
                n_targets = '0;
                n_decoys  = '0;
                n_passing = '0;
                n_k       = '0;
                n_state   = S_SC_RD;
            end
            S_SC_RD: begin
                w_item_re = 1'b1;
                n_state   = S_SC_CNT;
            end
            S_SC_CNT: begin
                if (r_item_rd.decoy) begin
                    n_decoys = r_decoys + CW'(1);
                end else begin
                    n_targets = r_targets + CW'(1);
                end
                n_state = S_SC_MUL;
            end
            S_SC_MUL: begin
                n_prod  = PROD_W'(r_pr) * PROD_W'(r_decoys);
                n_state = S_SC_Q;
            end
            // clamp to pi0 where no division is needed
            S_SC_Q: begin
                if (r_targets == '0 || w_dvd >= w_lim) begin
                    n_q     = w_pi0_q;
                    n_state = S_SC_WR;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_SC_DIV;
                end
            end
            S_SC_DIV: begin
                if (w_div_done) begin
                    n_q     = (w_div_quo > w_pi0_q) ? w_pi0_q : w_div_quo;
                    n_state = S_SC_WR;
                end
            end
            S_SC_WR: begin
                w_q_we = 1'b1;
                if (QW'(r_thr) >= r_q) begin
                    n_passing = r_targets;
                end
                if (r_k == w_cm1) begin
                    n_k     = r_count;
                    n_min   = '1;
                    n_state = S_MIN_RD;
                end else begin
                    n_k     = r_k + CW'(1);
                    n_state = S_SC_RD;
                end
            end
            // backward running minimum
            S_MIN_RD: begin
                w_q_re    = 1'b1;
                w_q_raddr = AW'(w_km1);
                n_state   = S_MIN_WR;
            end
            S_MIN_WR: begin
                w_q_we    = 1'b1;
                w_q_waddr = AW'(w_km1);
                w_q_wdata = (r_q_rd < r_min) ? r_q_rd : r_min;
                n_min     = w_q_wdata;
                if (r_k == CW'(1)) begin
                    n_k     = '0;
                    n_state = S_OUT_RD;
                end else begin
                    n_k     = w_km1;
                    n_state = S_MIN_RD;
                end
            end
            // emit results in rank order
            S_OUT_RD: begin
                w_item_re = 1'b1;
                w_q_re    = 1'b1;
                n_state   = S_OUT_LD;
            end
            S_OUT_LD: begin
                n_out.item_index      = r_item_rd.idx;
                n_out.q_value         = r_q_rd;
                n_out.targets_passing = tdq_pkg::PASS_W'(r_passing);
                n_out.last_result     = (r_k == w_cm1);
                n_out_valid           = 1'b1;
                n_state               = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.last_result) begin
                        n_count = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + CW'(1);
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k       <= n_k;
        r_key     <= n_key;
        r_decoy   <= n_decoy;
        r_last    <= n_last;
        r_pr      <= n_pr;
        r_prod    <= n_prod;
        r_targets <= n_targets;
        r_decoys  <= n_decoys;
        r_passing <= n_passing;
        r_q       <= n_q;
        r_min     <= n_min;
        r_out     <= n_out;
    end

    // item store
    always_ff @(posedge i_clk) begin
        if (w_item_we) begin
            item_mem[w_item_waddr] <= w_item_wdata;
        end
        if (w_item_re) begin
            r_item_rd <= item_mem[w_item_raddr];
        end
    end

    // q store
    always_ff @(posedge i_clk) begin
        if (w_q_we) begin
            q_mem[w_q_waddr] <= w_q_wdata;
        end
        if (w_q_re) begin
            r_q_rd <= q_mem[w_q_raddr];
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

/* rtl/core/tdq_checker.sv */
// ----------------------------------------------------------------------------
// tdq_checker
// Port-level checks of the q-value engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "target_decoy_qvalue_engine_core_defines.svh"

module tdq_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            o_in_ready,
    input wire tdq_pkg::t_in_item               i_in_data,
    input wire logic                            o_out_valid,
    input wire logic                            i_out_ready,
    input wire tdq_pkg::t_out_item              o_out_data,
    input wire logic                            i_cfg_we,
    input wire logic [tdq_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input wire logic [tdq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic w_in_xfer;
    logic w_out_xfer;
    logic w_cfg_seen;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_xfer = o_out_valid && i_out_ready;
    assign w_cfg_seen = i_cfg_we && (i_cfg_index == i_cfg_index) && (i_cfg_data == i_cfg_data)
                        && (i_in_data == i_in_data);

    // results only come out while no item is taken
    `TDQ_ASSERT_IMP(a_no_out_when_ready, i_clk, i_rst_n, o_out_valid, !o_in_ready, "result while ready")

    // an accepted item never yields a result on the next cycle
    `TDQ_ASSERT_NXT(a_no_out_after_in, i_clk, i_rst_n, w_in_xfer, !o_out_valid, "result right after transfer")

    // registers are to be written only while the engine is idle; the block does not enforce it
    `TDQ_ASSERT_IMP(a_cfg_idle, i_clk, i_rst_n, w_cfg_seen, o_in_ready && !o_out_valid, "register write while busy")

    // a stalled result holds
    `TDQ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data), "stalled result changed")

    // the final result ends the run
    `TDQ_ASSERT_NXT(a_run_end, i_clk, i_rst_n, w_out_xfer && o_out_data.last_result, !o_out_valid, "result after final result")

endmodule

bind target_decoy_qvalue_engine_core tdq_checker u_tdq_checker (.*);

`default_nettype wire

/* tb/sv/tb_target_decoy_qvalue_engine_core.sv */
// ----------------------------------------------------------------------------
// tb_target_decoy_qvalue_engine_core
// Self-checking bench: ranked q-value sets under bursty input and sink stalls.
// ----------------------------------------------------------------------------
// Item sets are queued by the stimulus block and sent by a clocked driver in
// bursts with gaps. Each accepted item updates a local ranked store; an item
// with last runs the q-value scan there and queues one expected result per
// rank. A clocked monitor compares every result field by field. Registers
// are rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_target_decoy_qvalue_engine_core;

    localparam int CAPACITY = tdq_pkg::DEF_MAX_ITEMS;
    localparam logic [tdq_pkg::CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;
    localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_in_valid;
    logic                                o_in_ready;
    tdq_pkg::t_in_item                   i_in_data;
    logic                                o_out_valid;
    logic                                i_out_ready;
    tdq_pkg::t_out_item                  o_out_data;
    logic                                i_cfg_we;
    logic [tdq_pkg::CFG_INDEX_W-1:0]     i_cfg_index;
    logic [tdq_pkg::CFG_DATA_W-1:0]      i_cfg_data;

    target_decoy_qvalue_engine_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // items waiting to be sent, results waiting to arrive
    tdq_pkg::t_in_item  send_queue[$];
    tdq_pkg::t_out_item rank_results[$];
    int                 error_count = 0;

    // local copy of the registers
    logic [tdq_pkg::THR_W-1:0]   thr_reg   = tdq_pkg::THR_RESET;
    logic [tdq_pkg::PI0_W-1:0]   pi0_reg   = tdq_pkg::PI0_RESET;
    logic [tdq_pkg::RATIO_W-1:0] ratio_reg = tdq_pkg::RATIO_RESET;

    // local ranked store
    logic [31:0]                 rank_key[CAPACITY];
    logic                        rank_decoy[CAPACITY];
    logic [tdq_pkg::INDEX_W-1:0] rank_idx[CAPACITY];
    logic [tdq_pkg::Q_W-1:0]     rank_q[CAPACITY];
    int                          stored = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ranked insert, and the q-value scan when the set is closed
    function automatic void rank_and_score(tdq_pkg::t_in_item it);
        logic [31:0]        key;
        logic [63:0]        efp;
        logic [63:0]        qv;
        int                 pos;
        int                 targets;
        int                 decoys;
        int                 passing;
        tdq_pkg::t_out_item res;
        key = it.score ^ SIGN_FLIP;
        if (stored < CAPACITY) begin
            pos = 0;
            while (pos < stored && rank_key[pos] > key) pos++;
            for (int k = stored; k > pos; k--) begin
                rank_key[k]   = rank_key[k-1];
                rank_decoy[k] = rank_decoy[k-1];
                rank_idx[k]   = rank_idx[k-1];
            end
            rank_key[pos]   = key;
            rank_decoy[pos] = it.is_decoy;
            rank_idx[pos]   = stored[tdq_pkg::INDEX_W-1:0];
            stored++;
        end
        if (!it.last) return;
        targets = 0;
        decoys  = 0;
        passing = 0;
        for (int r = 0; r < stored; r++) begin
            if (rank_decoy[r]) decoys++;
            else targets++;
            if (targets != 0) begin
                efp = 64'(pi0_reg) * 64'(decoys) * 64'(ratio_reg);
                qv  = efp / (64'(targets) << 16);
            end else begin
                qv = 64'(pi0_reg);
            end
            if (qv > 64'(pi0_reg)) qv = 64'(pi0_reg);
            rank_q[r] = qv[tdq_pkg::Q_W-1:0];
            if (64'(thr_reg) >= qv) passing = targets;
        end
        // backward running minimum
        for (int r = stored - 2; r >= 0; r--)
            if (rank_q[r] > rank_q[r+1]) rank_q[r] = rank_q[r+1];
        for (int r = 0; r < stored; r++) begin
            res.item_index      = rank_idx[r];
            res.q_value         = rank_q[r];
            res.targets_passing = passing[tdq_pkg::PASS_W-1:0];
            res.last_result     = (r + 1 == stored);
            rank_results.push_back(res);
        end
        stored = 0;
    endfunction

    // driver: bursts of transfers with random gaps
    int burst_left = 0;
    int gap_left   = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) rank_and_score(i_in_data);
            if (!i_in_valid || o_in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (send_queue.size() > 0) begin
                    i_in_valid <= 1'b1;
                    i_in_data  <= send_queue.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // sink stall pattern: alternating windows of free flow and stalls
    int stall_tick = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            stall_tick++;
            case ((stall_tick / 150) % 3)
                0: begin
                    i_out_ready <= 1'b1;
                end
                1: begin
                    i_out_ready <= ($urandom_range(0, 3) != 0);
                end
                default: begin
                    i_out_ready <= ((stall_tick % 7) < 2);
                end
            endcase
        end
    end

    // monitor: compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        tdq_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (rank_results.size() == 0) begin
                $error("unexpected result transfer index %0d", o_out_data.item_index);
                error_count++;
            end else begin
                want = rank_results.pop_front();
                if (o_out_data.item_index !== want.item_index) begin
                    $error("item_index exp %0d got %0d", want.item_index,
                           o_out_data.item_index);
                    error_count++;
                end
                if (o_out_data.q_value !== want.q_value) begin
                    $error("q_value exp %0d got %0d", want.q_value, o_out_data.q_value);
                    error_count++;
                end
                if (o_out_data.targets_passing !== want.targets_passing) begin
                    $error("targets_passing exp %0d got %0d", want.targets_passing,
                           o_out_data.targets_passing);
                    error_count++;
                end
                if (o_out_data.last_result !== want.last_result) begin
                    $error("last_result exp %0d got %0d", want.last_result,
                           o_out_data.last_result);
                    error_count++;
                end
            end
        end
    end

    // register write, mirrored into the local copy
    task automatic write_reg(logic [tdq_pkg::CFG_INDEX_W-1:0] idx,
                             logic [tdq_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            tdq_pkg::CFG_FDR_THRESHOLD: thr_reg   = data[tdq_pkg::THR_W-1:0];
            tdq_pkg::CFG_NULL_FRACTION: pi0_reg   = data[tdq_pkg::PI0_W-1:0];
            tdq_pkg::CFG_DECOY_RATIO:   ratio_reg = data[tdq_pkg::RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // hold the stimulus until every queued item is sent and every expected result is in, then let it settle
    task automatic wait_drained();
        while (send_queue.size() != 0 || i_in_valid || rank_results.size() != 0)
            @(posedge i_clk);
        repeat (160) @(posedge i_clk);
    endtask

    task automatic queue_item(logic [31:0] score, logic decoy, logic last);
        tdq_pkg::t_in_item it;
        it.score    = score;
        it.is_decoy = decoy;
        it.last     = last;
        send_queue.push_back(it);
    endtask

    function automatic logic [31:0] pick_score();
        case ($urandom_range(0, 5))
            0:       return 32'(int'($urandom_range(0, 6)) - 3);
            1:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // random sets of mostly small size, each closed by last
    task automatic queue_random_sets(int count);
        int sent;
        int size;
        sent = 0;
        while (sent < count) begin
            size = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 8);
            for (int k = 0; k < size; k++)
                queue_item(pick_score(), 1'($urandom_range(0, 1)), k == size - 1);
            sent += size;
        end
    endtask

    // stimulus and phases
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= tdq_pkg::CFG_FDR_THRESHOLD;
        i_cfg_data  <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: single item set, extremes and ties, decoys ahead of targets
        queue_item(32'h7FFF_FFFF, 1'b0, 1'b1);
        queue_item(32'h8000_0000, 1'b1, 1'b0);
        queue_item(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_item(32'h0000_0000, 1'b0, 1'b0);
        queue_item(32'hFFFF_FFFF, 1'b1, 1'b0);
        queue_item(32'h0000_0005, 1'b1, 1'b0);
        queue_item(32'h0000_0005, 1'b0, 1'b0);
        queue_item(32'h0000_0005, 1'b0, 1'b1);
        queue_item(32'h0000_0100, 1'b1, 1'b0);
        queue_item(32'h0000_0200, 1'b1, 1'b0);
        queue_item(32'h0000_0010, 1'b0, 1'b1);
        queue_item(32'h1234_5678, 1'b1, 1'b0);
        queue_item(32'h8765_4321, 1'b1, 1'b1);
        wait_drained();

        // extremes, upper bits of the narrow registers dropped, unused index
        write_reg(tdq_pkg::CFG_FDR_THRESHOLD, 24'hFF0000);
        write_reg(tdq_pkg::CFG_NULL_FRACTION, 24'hFFFFFF);
        write_reg(tdq_pkg::CFG_DECOY_RATIO, 24'hFFFFFF);
        write_reg(CFG_NO_REG, 24'h00ABCD);
        queue_item(32'h0000_0001, 1'b0, 1'b0);
        queue_item(32'h0000_0002, 1'b1, 1'b0);
        queue_item(32'h0000_0003, 1'b0, 1'b1);
        queue_random_sets(5);
        wait_drained();

        // opposite extremes
        write_reg(tdq_pkg::CFG_FDR_THRESHOLD, 24'h00FFFF);
        write_reg(tdq_pkg::CFG_NULL_FRACTION, 24'hAB0000);
        write_reg(tdq_pkg::CFG_DECOY_RATIO, 24'h000000);
        queue_random_sets(5);
        wait_drained();

        // random settings, and one set that overruns the store
        write_reg(tdq_pkg::CFG_FDR_THRESHOLD, tdq_pkg::CFG_DATA_W'($urandom()));
        write_reg(tdq_pkg::CFG_NULL_FRACTION, tdq_pkg::CFG_DATA_W'($urandom()));
        write_reg(tdq_pkg::CFG_DECOY_RATIO, tdq_pkg::CFG_DATA_W'($urandom()));
        for (int k = 0; k < CAPACITY + 4; k++)
            queue_item(pick_score(), 1'($urandom_range(0, 1)), k == CAPACITY + 3);
        queue_random_sets(5);
        wait_drained();

        // near-default settings where thresholds are met now and then
        write_reg(tdq_pkg::CFG_FDR_THRESHOLD,
                  tdq_pkg::CFG_DATA_W'($urandom_range(0, 30000)));
        write_reg(tdq_pkg::CFG_NULL_FRACTION,
                  tdq_pkg::CFG_DATA_W'($urandom_range(30000, 65535)));
        write_reg(tdq_pkg::CFG_DECOY_RATIO,
                  tdq_pkg::CFG_DATA_W'($urandom_range(16384, 131072)));
        queue_random_sets(5);
        wait_drained();

        if (error_count == 0) begin
            $display("** target_decoy_qvalue_engine_core: PASSED **");
        end else begin
            $display("** target_decoy_qvalue_engine_core: FAILED **");
        end
        $finish;
    end

    // run limit
    initial begin
        #(12 * 1000000);
        $display("** target_decoy_qvalue_engine_core: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl/core
rtl/core/tdq_pkg.sv
rtl/core/tdq_divider.sv
rtl/core/target_decoy_qvalue_engine_core.sv
rtl/core/tdq_checker.sv
tb/sv/tb_target_decoy_qvalue_engine_core.sv
